[design/message_tag_list_parser_assert.svh]
// Assertion macros for the tag list parser
// No dependencies; taken in by the RTL files that carry assertions
`ifndef MESSAGE_TAG_LIST_PARSER_ASSERT_SVH
`define MESSAGE_TAG_LIST_PARSER_ASSERT_SVH

// property checked at every rising clock edge outside reset
`define MTLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication, with the property checked in the next cycle
`define MTLP_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[design/mtlp_pkg.sv]
// Package for the tag list parser: character codes, result kinds, slot type
// and the tag arithmetic helpers. No dependencies.
package mtlp_pkg;

   // default and supported range of the list length
   localparam int MAX_TAGS_DEFAULT = 64;
   // width that holds any counter value up to the largest list length
   localparam int COUNT_W = 8;

   // character codes
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_BRACKET = 8'h5B;
   localparam logic [7:0] CHAR_COMMA   = 8'h2C;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;

   // result kinds
   localparam logic ITEM_KIND_TAG     = 1'b0;
   localparam logic ITEM_KIND_SUMMARY = 1'b1;

   // the results of one accepted word: an optional tag and an optional summary
   typedef struct packed {
      logic        has_tag;
      logic        has_sum;
      logic [15:0] value;
      logic [5:0]  pos;
      logic [6:0]  total;
      logic [5:0]  act;
      logic        err;
   } slot_type;

   // accumulator times ten plus a digit, wrapping at 16 bits
   function automatic logic [15:0] acc_step(input logic [15:0] acc, input logic [3:0] digit);
      return (acc << 3) + (acc << 1) + {12'd0, digit};
   endfunction

   // signed tag from accumulator and minus flag; a lone minus gives -1
   function automatic logic [15:0] tag_of(input logic [15:0] acc, input logic neg);
      logic [15:0] res;
      if (!neg) begin
         res = acc;
      end else if (acc == 16'd0) begin
         res = 16'hFFFF;
      end else begin
         res = 16'd0 - acc;
      end
      return res;
   endfunction

endpackage

[design/message_tag_list_parser.sv]
// Tag list parser top level: byte parser state and a two-slot result queue
// Depends on mtlp_pkg and message_tag_list_parser_assert.svh
//
//   channel | direction | handshake            | payload
//   req_    | in        | req_valid/req_stall  | char_byte, end_of_string, expected_count
//   rsp_    | out       | rsp_valid/rsp_stall  | tag or finish summary, last_of_run
//
// One word is taken per cycle while req_stall is low; its results are registered in the head slot,
// or in the second slot if the head is occupied. An end word with room left in the list gives two results,
// leaving the head in two steps; the second slot absorbs that, so req_stall rises only when both slots are occupied.
// Reset (synchronous, active high) clears the parser state and empties the queue.
// A stall on rsp_ holds the head result; input keeps flowing until the queue is full.
module message_tag_list_parser
   import mtlp_pkg::*;
#(
   parameter int MAX_TAGS = MAX_TAGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_end_of_string,
   input  logic [6:0]         req_expected_count,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_item_kind,
   output logic signed [15:0] rsp_tag_value,
   output logic [5:0]         rsp_tag_position,
   output logic [6:0]         rsp_tag_total,
   output logic [5:0]         rsp_active_position,
   output logic               rsp_count_error,
   output logic               rsp_last_of_run
);

   localparam int CNT_W = $clog2(MAX_TAGS + 1);

   logic [15:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [5:0]       act_ff, act_in;

   slot_type head_ff, head_in, tail_ff, tail_in, slot;
   logic     head_valid_ff, head_valid_in, tail_valid_ff, tail_valid_in;

   logic               accept, push, pop, head_done, full;
   logic [COUNT_W-1:0] cnt_w, total_w;
   logic [15:0]        cur_tag;

   assign accept  = req_valid && !req_stall;
   assign cnt_w   = COUNT_W'(cnt_ff);
   assign full    = cnt_w == COUNT_W'(MAX_TAGS);
   assign cur_tag = tag_of(acc_ff, neg_ff);

   // parse one word: next state and the results it causes
   always_comb begin
      acc_in  = acc_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      act_in  = act_ff;
      slot    = '0;
      total_w = cnt_w;
      if (accept) begin
         if (req_end_of_string) begin
            if (!full) begin
               slot.has_tag = 1'b1;
               slot.value   = cur_tag;
               slot.pos     = cnt_w[5:0];
               total_w      = cnt_w + COUNT_W'(1);
            end
            slot.has_sum = 1'b1;
            slot.total   = total_w[6:0];
            slot.act     = act_ff;
            slot.err     = COUNT_W'(req_expected_count) > total_w;
            acc_in       = '0;
            neg_in       = 1'b0;
            cnt_in       = '0;
         end else if (!full) begin
            case (req_char_byte)
               CHAR_MINUS: begin
                  neg_in = 1'b1;
               end
               CHAR_BRACKET: begin
                  act_in = cnt_w[5:0];
               end
               CHAR_COMMA: begin
                  slot.has_tag = 1'b1;
                  slot.value   = cur_tag;
                  slot.pos     = cnt_w[5:0];
                  acc_in       = '0;
                  neg_in       = 1'b0;
                  cnt_in       = cnt_ff + CNT_W'(1);
               end
               default: begin
                  if (req_char_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
                     acc_in = acc_step(acc_ff, 4'(req_char_byte - CHAR_ZERO));
                  end
               end
            endcase
         end
      end
   end

   assign push = accept && (slot.has_tag || slot.has_sum);

   // two-slot result queue; a tag-plus-summary slot pops in two steps
   assign pop       = rsp_valid && !rsp_stall;
   assign head_done = pop && !(head_ff.has_tag && head_ff.has_sum);
   assign req_stall = tail_valid_ff;

   always_comb begin
      head_in       = head_ff;
      head_valid_in = head_valid_ff;
      tail_in       = tail_ff;
      tail_valid_in = tail_valid_ff;
      if (head_valid_ff && !head_done) begin
         if (pop) begin
            head_in.has_tag = 1'b0;
         end
         if (!tail_valid_ff && push) begin
            tail_in       = slot;
            tail_valid_in = 1'b1;
         end
      end else if (tail_valid_ff) begin
         head_in       = tail_ff;
         head_valid_in = 1'b1;
         tail_valid_in = 1'b0;
      end else begin
         head_in       = slot;
         head_valid_in = push;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff        <= '0;
         neg_ff        <= 1'b0;
         cnt_ff        <= '0;
         act_ff        <= '0;
         head_valid_ff <= 1'b0;
         tail_valid_ff <= 1'b0;
      end else begin
         acc_ff        <= acc_in;
         neg_ff        <= neg_in;
         cnt_ff        <= cnt_in;
         act_ff        <= act_in;
         head_valid_ff <= head_valid_in;
         tail_valid_ff <= tail_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // result word from the head slot
   assign rsp_valid           = head_valid_ff;
   assign rsp_item_kind       = head_ff.has_tag ? ITEM_KIND_TAG : ITEM_KIND_SUMMARY;
   assign rsp_tag_value       = head_ff.has_tag ? $signed(head_ff.value) : 16'sd0;
   assign rsp_tag_position    = head_ff.has_tag ? head_ff.pos : 6'd0;
   assign rsp_tag_total       = head_ff.has_tag ? 7'd0 : head_ff.total;
   assign rsp_active_position = head_ff.has_tag ? 6'd0 : head_ff.act;
   assign rsp_count_error     = head_ff.has_tag ? 1'b0 : head_ff.err;
   assign rsp_last_of_run     = !(head_ff.has_tag && head_ff.has_sum);

`include "message_tag_list_parser_assert.svh"

   // queue fills from the head
   `MTLP_ASSERT(a_tail_needs_head, !tail_valid_ff || head_valid_ff, "tail slot without head")
   // list counter never passes its limit
   `MTLP_ASSERT(a_count_bound, cnt_w <= COUNT_W'(MAX_TAGS), "tag counter beyond limit")
   // an end word restarts the list
   `MTLP_ASSERT_NEXT(a_end_clears, accept && req_end_of_string, cnt_ff == '0 && acc_ff == '0 && !neg_ff, "list not cleared after end word")
   // taking the tag of a combined slot leaves its summary in the head
   `MTLP_ASSERT_NEXT(a_split_pop, pop && head_ff.has_tag && head_ff.has_sum, head_valid_ff && head_ff.has_sum && !head_ff.has_tag, "summary lost after tag")

endmodule
